### rtl/vpft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpft_pkg: shared definitions for the virtual PCI function table
// Operation and status codes, lifecycle flag positions, the slot store write
// request, and the fixed config-space template.
// ----------------------------------------------------------------------------
package vpft_pkg;

  localparam int unsigned MAX_SLOTS    = 32;
  localparam int unsigned SLOT_W       = $clog2(MAX_SLOTS);
  localparam int unsigned CONFIG_BYTES = 256;
  localparam int unsigned FLAG_W       = 7;
  localparam int unsigned GEN_W        = 64;
  localparam int unsigned ACT_W        = 6;

  // Bit positions inside the lifecycle flag word.
  localparam int unsigned F_LOGICAL = 0;
  localparam int unsigned F_PRESENT = 1;
  localparam int unsigned F_READY   = 2;
  localparam int unsigned F_MATCH   = 3;
  localparam int unsigned F_BOUND   = 4;
  localparam int unsigned F_ONLINE  = 5;
  localparam int unsigned F_QUAR    = 6;

  // Register index of the only configuration register.
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef logic [FLAG_W-1:0] flags_t;
  typedef logic [GEN_W-1:0]  gen_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_PREPARE  = 4'd1,
    OP_ENABLE   = 4'd2,
    OP_PROBE    = 4'd3,
    OP_REMOVE   = 4'd4,
    OP_RESCAN   = 4'd5,
    OP_READ_CFG = 4'd6,
    OP_WRITE_CFG= 4'd7,
    OP_QUERY    = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVAL    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_NOTPRES  = 3'd4,
    ST_BUSY     = 3'd5,
    ST_NOTREADY = 3'd6,
    ST_RO       = 3'd7
  } status_e;

  // Write request into the slot store.
  typedef struct packed {
    logic      flags_en;
    logic      gen_en;
    slot_idx_t addr;
    flags_t    flags;
    gen_t      gen;
  } store_wr_t;

  // Config-space template: the header pattern repeats at bytes 44..47.
  function automatic logic [7:0] template_byte(input logic [15:0] addr);
    logic [7:0] val;
    begin
      case (addr)
        16'd0, 16'd44: val = 8'h46;
        16'd1, 16'd45: val = 8'h4d;
        16'd2, 16'd46: val = 8'h01;
        16'd11:        val = 8'h12;
        default:       val = 8'h00;
      endcase
      return val;
    end
  endfunction

endpackage

### rtl/virtual_pci_function_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_pci_function_table_core: table of virtual PCI functions
// Keeps lifecycle flags and a generation number for each function slot and
// executes add, lifecycle, config-space and query operations on them.
// ----------------------------------------------------------------------------
// Usage:
//   An operation enters on the input valid/ready channel; each one produces
//   exactly one result transaction on the output channel (status, assigned
//   slot, read data, flags and generation).
//   The slot entry is read from the store at the accepting edge, the result is
//   computed and written back in the next cycle, and the result is presented
//   from an output register after the edge that ends that cycle, which is when
//   out_valid_o rises. One operation is in flight at a time; a new one is
//   accepted in the same cycle its predecessor's result is taken, so each
//   operation waits for the store read and the read-modify-write of the one
//   before it to finish.
//   A vector of logical-present bits in flip-flops marks occupied slots; it
//   feeds the free-slot priority encoder and masks store entries of free
//   slots to zero, so reset empties the table at once with no clearing pass.
//   Reset also sets active_slots to 32. While the receiver stalls, the result
//   holds and no new operation is accepted.
//   active_slots is written through the APB port at address 0; the user must
//   write it only while the block is idle, and the block does not enforce it.
// ----------------------------------------------------------------------------
module virtual_pci_function_table_core
  import vpft_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // Operation channel
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    op_i,
  input  logic [7:0]    slot_i,
  input  logic [15:0]   byte_offset_i,
  input  logic [7:0]    access_width_i,
  input  logic [31:0]   write_value_i,
  input  logic [63:0]   new_generation_i,
  input  logic          probe_ok_i,
  // Result channel
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [4:0]    assigned_slot_o,
  output logic [31:0]   read_data_o,
  output logic [6:0]    slot_flags_o,
  output logic [63:0]   slot_generation_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [ACT_W-1:0]     active_q;
  logic [MAX_SLOTS-1:0] logical_q, logical_d;

  // Latched operation.
  logic [3:0]  op_q;
  logic [7:0]  slot_q;
  logic [15:0] off_q;
  logic [7:0]  width_q;
  logic [31:0] wval_q;
  gen_t        gen_q;
  logic        probe_ok_q;

  // Result registers.
  status_e     status_q, status_d;
  slot_idx_t   assigned_q, assigned_d;
  logic [31:0] rdata_q, rdata_d;
  flags_t      qflags_q, qflags_d;
  gen_t        qgen_q, qgen_d;

  logic      in_accept;
  store_wr_t wr;
  flags_t    rd_flags;
  gen_t      rd_gen;

  // APB port: single register, writes take effect on the access cycle.
  assign pready = 1'b1;
  assign prdata = {{(32-ACT_W){1'b0}}, active_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_W'(MAX_SLOTS);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_SLOTS)) begin
      active_q <= pwdata[ACT_W-1:0];
    end
  end

  // Handshake.
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_RESP) && out_ready_i);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RESP);

  // Capture the operation on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= op_i;
      slot_q     <= slot_i;
      off_q      <= byte_offset_i;
      width_q    <= access_width_i;
      wval_q     <= write_value_i;
      gen_q      <= new_generation_i;
      probe_ok_q <= probe_ok_i;
    end
  end

  // Slot store, read at acceptance.
  vpft_store u_store (
    .clk_i      (clk_i),
    .rd_en_i    (in_accept),
    .rd_addr_i  (slot_i[SLOT_W-1:0]),
    .wr_i       (wr),
    .rd_flags_o (rd_flags),
    .rd_gen_o   (rd_gen)
  );

  // Free-slot priority encoder over the logical-present bits.
  logic [MAX_SLOTS-1:0] free_mask;
  slot_idx_t            free_idx;
  logic                 free_found;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_mask[i] = !logical_q[i] && ({1'b0, active_q} > (ACT_W+1)'(i));
    end
    free_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    free_found = |free_mask;
  end

  // Common operand checks.
  slot_idx_t   s_idx;
  flags_t      cur_flags;
  gen_t        cur_gen;
  logic        regs_ok, in_range, width_ok, span_ok, nz_data;
  logic [16:0] span_end;
  logic [31:0] tmpl_data;

  assign s_idx     = slot_q[SLOT_W-1:0];
  assign cur_flags = logical_q[s_idx] ? rd_flags : '0;
  assign cur_gen   = logical_q[s_idx] ? rd_gen : '0;
  assign regs_ok   = (active_q != '0) && (active_q <= ACT_W'(MAX_SLOTS));
  assign in_range  = {2'b0, slot_q} < {4'b0, active_q};
  assign width_ok  = (width_q == 8'd1) || (width_q == 8'd2) || (width_q == 8'd4);
  assign span_end  = {1'b0, off_q} + {9'b0, width_q};
  assign span_ok   = (off_q < 16'(CONFIG_BYTES)) && (span_end <= 17'(CONFIG_BYTES));

  // Little-endian template bytes and the nonzero-byte check of a write.
  always_comb begin
    tmpl_data[7:0]   = template_byte(off_q);
    tmpl_data[15:8]  = (width_q != 8'd1) ? template_byte(off_q + 16'd1) : 8'h00;
    tmpl_data[23:16] = (width_q == 8'd4) ? template_byte(off_q + 16'd2) : 8'h00;
    tmpl_data[31:24] = (width_q == 8'd4) ? template_byte(off_q + 16'd3) : 8'h00;
    nz_data = (wval_q[7:0] != 8'h00) ||
              ((width_q != 8'd1) && (wval_q[15:8] != 8'h00)) ||
              ((width_q == 8'd4) && (wval_q[31:16] != 16'h0000));
  end

  // Execute: compute the result and the store write-back.
  always_comb begin
    flags_t f;
    f          = cur_flags;
    status_d   = ST_OK;
    assigned_d = '0;
    rdata_d    = '0;
    qflags_d   = '0;
    qgen_d     = '0;
    logical_d  = logical_q;
    wr         = '0;
    wr.addr    = s_idx;

    case (op_q)
      OP_ADD: begin
        if (!regs_ok || (gen_q == '0)) begin
          status_d = ST_INVAL;
        end else if (!free_found) begin
          status_d = ST_NOSPACE;
        end else begin
          wr.flags_en = 1'b1;
          wr.gen_en   = 1'b1;
          wr.addr     = free_idx;
          wr.flags    = flags_t'((1 << F_LOGICAL) | (1 << F_PRESENT));
          wr.gen      = gen_q;
          logical_d[free_idx] = 1'b1;
          assigned_d = free_idx;
        end
      end
      OP_PREPARE, OP_ENABLE, OP_PROBE, OP_REMOVE, OP_RESCAN, OP_QUERY: begin
        if (!regs_ok) begin
          status_d = ST_INVAL;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          case (op_q)
            OP_PREPARE: begin
              if (!f[F_PRESENT] || f[F_QUAR]) begin
                status_d = ST_NOTPRES;
              end else if (f[F_MATCH]) begin
                status_d = ST_BUSY;
              end else begin
                f[F_READY] = 1'b1;
              end
            end
            OP_ENABLE: begin
              if (!f[F_PRESENT] || f[F_QUAR]) begin
                status_d = ST_NOTPRES;
              end else if (!f[F_READY] || f[F_MATCH]) begin
                status_d = ST_NOTREADY;
              end else begin
                f[F_MATCH] = 1'b1;
              end
            end
            OP_PROBE: begin
              if (!f[F_PRESENT] || !f[F_MATCH]) begin
                status_d = ST_NOTREADY;
              end else begin
                f[F_MATCH] = 1'b0;
                f[F_READY] = 1'b0;
                if (probe_ok_q) begin
                  f[F_BOUND]  = 1'b1;
                  f[F_ONLINE] = 1'b1;
                end else begin
                  // A failed probe takes the function offline and quarantines it.
                  f[F_PRESENT] = 1'b0;
                  f[F_BOUND]   = 1'b0;
                  f[F_ONLINE]  = 1'b0;
                  f[F_QUAR]    = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (!f[F_LOGICAL]) begin
                status_d = ST_NOTPRES;
              end else begin
                f = '0;
                wr.gen_en = 1'b1;
                wr.gen    = '0;
                logical_d[s_idx] = 1'b0;
              end
            end
            OP_RESCAN: begin
              if (!f[F_LOGICAL]) begin
                status_d = ST_NOTPRES;
              end else if (f[F_PRESENT]) begin
                status_d = ST_BUSY;
              end else begin
                f = flags_t'((1 << F_LOGICAL) | (1 << F_PRESENT));
              end
            end
            default: begin
              qflags_d = f;
              qgen_d   = cur_gen;
            end
          endcase
          wr.flags_en = (status_d == ST_OK);
          wr.flags    = f;
        end
      end
      OP_READ_CFG: begin
        if (!width_ok || !regs_ok) begin
          status_d = ST_INVAL;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else if (!cur_flags[F_PRESENT]) begin
          status_d = ST_NOTPRES;
        end else if (!span_ok) begin
          status_d = ST_RANGE;
        end else begin
          rdata_d = tmpl_data;
        end
      end
      OP_WRITE_CFG: begin
        // No byte of the config space is writable.
        if (!width_ok || !span_ok || !regs_ok) begin
          status_d = ST_INVAL;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else if (!cur_flags[F_PRESENT]) begin
          status_d = ST_NOTPRES;
        end else if (nz_data) begin
          status_d = ST_RO;
        end
      end
      default: begin
        status_d = ST_INVAL;
      end
    endcase

    if (state_q != S_EXEC) begin
      wr.flags_en = 1'b0;
      wr.gen_en   = 1'b0;
      logical_d   = logical_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end else if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      logical_q <= '0;
    end else begin
      state_q   <= state_d;
      logical_q <= logical_d;
    end
  end

  // Result register, loaded at the end of the execute cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      status_q   <= status_d;
      assigned_q <= assigned_d;
      rdata_q    <= rdata_d;
      qflags_q   <= qflags_d;
      qgen_q     <= qgen_d;
    end
  end

  assign status_o          = status_q;
  assign assigned_slot_o   = assigned_q;
  assign read_data_o       = rdata_q;
  assign slot_flags_o      = qflags_q;
  assign slot_generation_o = qgen_q;

endmodule

### rtl/vpft_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpft_store: per-slot lifecycle flags and generation numbers
// Two synchronous memories with one write port and one registered read port.
// Entries are not reset; the caller masks entries of free slots.
// ----------------------------------------------------------------------------
module vpft_store
  import vpft_pkg::*;
(
  input  logic      clk_i,
  input  logic      rd_en_i,
  input  slot_idx_t rd_addr_i,
  input  store_wr_t wr_i,
  output flags_t    rd_flags_o,
  output gen_t      rd_gen_o
);

  flags_t flags_mem [MAX_SLOTS];
  gen_t   gen_mem   [MAX_SLOTS];
  flags_t rd_flags_q;
  gen_t   rd_gen_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.flags_en) begin
      flags_mem[wr_i.addr] <= wr_i.flags;
    end
    if (wr_i.gen_en) begin
      gen_mem[wr_i.addr] <= wr_i.gen;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_flags_q <= flags_mem[rd_addr_i];
      rd_gen_q   <= gen_mem[rd_addr_i];
    end
  end

  assign rd_flags_o = rd_flags_q;
  assign rd_gen_o   = rd_gen_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for virtual_pci_function_table_core
// Drives operations on the valid/ready input channel and predicts every result
// with a cycle-free model of the slot table (lifecycle flags, generations, the
// config-space header). Results are checked in order, field by field. The run
// walks through several slot-count settings written over APB, good and bad.
// ----------------------------------------------------------------------------
module tb;
  import vpft_pkg::*;

  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned N_PHASES   = 8;
  localparam logic [2:0]  SLOTS_ADDR = 3'(4 * REG_ACTIVE_SLOTS);

  // Config-space header bytes; the same pattern repeats at byte 44.
  localparam logic [7:0] HDR_B0 = 8'h46;
  localparam logic [7:0] HDR_B1 = 8'h4d;
  localparam logic [7:0] HDR_B2 = 8'h01;
  localparam logic [7:0] HDR_B11 = 8'h12;
  localparam int unsigned HDR_MIRROR = 44;

  // One operation as offered on the input channel.
  typedef struct {
    logic [3:0]  op;
    logic [7:0]  slot;
    logic [15:0] offset;
    logic [7:0]  width;
    logic [31:0] wdata;
    gen_t        gen;
    logic        probe_ok;
    bit          drain;
  } fn_op_t;

  // One predicted result transaction.
  typedef struct {
    logic [3:0]  op;
    status_e     status;
    logic [4:0]  slot;
    logic [31:0] rdata;
    flags_t      flags;
    gen_t        gen;
  } fn_result_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  op_i = '0;
  logic [7:0]  slot_i = '0;
  logic [15:0] byte_offset_i = '0;
  logic [7:0]  access_width_i = '0;
  logic [31:0] write_value_i = '0;
  logic [63:0] new_generation_i = '0;
  logic        probe_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [4:0]  assigned_slot_o;
  logic [31:0] read_data_o;
  logic [6:0]  slot_flags_o;
  logic [63:0] slot_generation_o;

  // Shadow copy of the slot table and its register
  flags_t           fn_flags [MAX_SLOTS] = '{default: '0};
  gen_t             fn_gen [MAX_SLOTS] = '{default: '0};
  logic [ACT_W-1:0] slots_in_use = 6'd32;

  fn_op_t     pending_ops[$];
  fn_result_t expected_results[$];
  fn_op_t     cur_op;

  int n_ops_issued = 0;
  int n_results_seen = 0;
  int fail_count = 0;
  int n_settings = 0;
  int n_chunks = 0;
  int stat_hits [8] = '{default: 0};
  bit gaps_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit long_hold_done = 1'b0;

  virtual_pci_function_table_core u_top (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every failure is counted; only the first ten are printed.
  function automatic bit count_failure();
    fail_count++;
    return fail_count <= 10;
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] header_byte(input int unsigned addr);
    int unsigned rel;
    rel = (addr >= HDR_MIRROR) ? addr - HDR_MIRROR : addr;
    if (addr == 11) return HDR_B11;
    if (addr >= HDR_MIRROR + 4) return 8'h00;
    case (rel)
      0: return HDR_B0;
      1: return HDR_B1;
      2: return HDR_B2;
      default: return 8'h00;
    endcase
  endfunction

  function automatic status_e slot_verdict(input logic [7:0] slot, input logic cfg_ok);
    if (!cfg_ok) return ST_INVAL;
    if (slot >= slots_in_use) return ST_RANGE;
    return ST_OK;
  endfunction

  // Applies one operation to the shadow table and returns its result.
  function automatic fn_result_t apply_table_op(input fn_op_t it);
    fn_result_t res;
    flags_t     f;
    logic [4:0] idx;
    logic       cfg_ok;
    logic       width_ok;
    logic       span_ok;
    bit         placed;
    res.op = it.op;
    res.status = ST_OK;
    res.slot = '0;
    res.rdata = '0;
    res.flags = '0;
    res.gen = '0;
    idx = it.slot[4:0];
    f = fn_flags[idx];
    cfg_ok = (slots_in_use >= 1) && (slots_in_use <= MAX_SLOTS);
    width_ok = (it.width == 1) || (it.width == 2) || (it.width == 4);
    span_ok = (it.offset < CONFIG_BYTES) && (it.width <= CONFIG_BYTES - it.offset);
    case (it.op)
      OP_ADD: begin
        if (!cfg_ok || it.gen == '0) begin
          res.status = ST_INVAL;
        end else begin
          // First free slot below the slot count wins.
          res.status = ST_NOSPACE;
          placed = 1'b0;
          for (int i = 0; i < slots_in_use; i++) begin
            if (!placed && !fn_flags[i][F_LOGICAL]) begin
              fn_flags[i] = '0;
              fn_flags[i][F_LOGICAL] = 1'b1;
              fn_flags[i][F_PRESENT] = 1'b1;
              fn_gen[i] = it.gen;
              res.slot = 5'(i);
              res.status = ST_OK;
              placed = 1'b1;
            end
          end
        end
      end
      OP_PREPARE, OP_ENABLE, OP_PROBE, OP_REMOVE, OP_RESCAN, OP_QUERY: begin
        res.status = slot_verdict(it.slot, cfg_ok);
        if (res.status == ST_OK) begin
          case (it.op)
            OP_PREPARE: begin
              if (!f[F_PRESENT] || f[F_QUAR]) res.status = ST_NOTPRES;
              else if (f[F_MATCH]) res.status = ST_BUSY;
              else f[F_READY] = 1'b1;
            end
            OP_ENABLE: begin
              if (!f[F_PRESENT] || f[F_QUAR]) res.status = ST_NOTPRES;
              else if (!f[F_READY] || f[F_MATCH]) res.status = ST_NOTREADY;
              else f[F_MATCH] = 1'b1;
            end
            OP_PROBE: begin
              if (!f[F_PRESENT] || !f[F_MATCH]) begin
                res.status = ST_NOTREADY;
              end else begin
                // A successful probe binds; a failed one quarantines.
                f[F_MATCH] = 1'b0;
                f[F_READY] = 1'b0;
                if (it.probe_ok) begin
                  f[F_BOUND] = 1'b1;
                  f[F_ONLINE] = 1'b1;
                end else begin
                  f[F_PRESENT] = 1'b0;
                  f[F_BOUND] = 1'b0;
                  f[F_ONLINE] = 1'b0;
                  f[F_QUAR] = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (!f[F_LOGICAL]) begin
                res.status = ST_NOTPRES;
              end else begin
                f = '0;
                fn_gen[idx] = '0;
              end
            end
            OP_RESCAN: begin
              if (!f[F_LOGICAL]) begin
                res.status = ST_NOTPRES;
              end else if (f[F_PRESENT]) begin
                res.status = ST_BUSY;
              end else begin
                f = '0;
                f[F_LOGICAL] = 1'b1;
                f[F_PRESENT] = 1'b1;
              end
            end
            default: begin
              res.flags = f;
              res.gen = fn_gen[idx];
            end
          endcase
          fn_flags[idx] = f;
        end
      end
      OP_READ_CFG: begin
        if (!width_ok) begin
          res.status = ST_INVAL;
        end else begin
          res.status = slot_verdict(it.slot, cfg_ok);
          if (res.status == ST_OK) begin
            if (!f[F_PRESENT]) res.status = ST_NOTPRES;
            else if (!span_ok) res.status = ST_RANGE;
            else
              for (int b = 0; b < it.width; b++)
                res.rdata |= 32'(header_byte(it.offset + b)) << (8 * b);
          end
        end
      end
      OP_WRITE_CFG: begin
        // No byte is writable: any nonzero byte in the access is refused.
        if (!width_ok || !span_ok) begin
          res.status = ST_INVAL;
        end else begin
          res.status = slot_verdict(it.slot, cfg_ok);
          if (res.status == ST_OK) begin
            if (!f[F_PRESENT]) res.status = ST_NOTPRES;
            else
              for (int b = 0; b < it.width; b++)
                if (it.wdata[8*b +: 8] != 8'h00) res.status = ST_RO;
          end
        end
      end
      default: res.status = ST_INVAL;
    endcase
    stat_hits[res.status]++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Operation driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : op_driver
    logic fire;
    int   in_flight;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        expected_results.push_back(apply_table_op(cur_op));
        n_ops_issued <= n_ops_issued + 1;
      end
      in_flight = n_ops_issued + int'(fire) - n_results_seen
                - int'(out_valid_o && out_ready_i);
      // The channel is free once the current transaction is taken.
      if (fire || !in_valid_i) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0 && !(pending_ops[0].drain && in_flight != 0)) begin
          cur_op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_op.op;
          slot_i <= cur_op.slot;
          byte_offset_i <= cur_op.offset;
          access_width_i <= cur_op.width;
          write_value_i <= cur_op.wdata;
          new_generation_i <= cur_op.gen;
          probe_ok_i <= cur_op.probe_ok;
          send_gap = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_ready
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && n_results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = gaps_on ? pick_gap() : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    fn_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results_seen <= n_results_seen + 1;
      if (expected_results.size() == 0) begin
        if (count_failure())
          $display("[%0t] unexpected result: status %0d slot %0d data %h", $realtime,
                   status_o, assigned_slot_o, read_data_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || assigned_slot_o !== want.slot ||
            read_data_o !== want.rdata || slot_flags_o !== want.flags ||
            slot_generation_o !== want.gen) begin
          if (count_failure())
            $display({"[%0t] mismatch op %0d: status %0d/%0d slot %0d/%0d ",
                      "data %h/%h flags %h/%h gen %h/%h (expected/actual)"},
                     $realtime, want.op, want.status, status_o, want.slot,
                     assigned_slot_o, want.rdata, read_data_o, want.flags,
                     slot_flags_o, want.gen, slot_generation_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_width();
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 2))
        0: return 8'd1;
        1: return 8'd2;
        default: return 8'd4;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 63));
    if (r < 75) return 16'($urandom_range(240, 255));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [31:0] pick_wdata();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return '0;
    if (r < 60) return 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic gen_t pick_generation();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 25) return gen_t'($urandom_range(1, 3));
    return {$urandom, $urandom};
  endfunction

  // Slots cluster low, where adds put functions; some fall out of range.
  function automatic logic [7:0] pick_slot(input int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cnt >= 1 && cnt <= MAX_SLOTS) begin
      if (r < 50) return 8'($urandom_range(0, ((cnt < 8) ? cnt : 8) - 1));
      if (r < 85) return 8'($urandom_range(0, cnt - 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Fields an operation does not use still carry random values.
  function automatic fn_op_t make_op(input logic [3:0] op, input logic [7:0] slot);
    fn_op_t it;
    it.op = op;
    it.slot = slot;
    it.offset = pick_offset();
    it.width = pick_width();
    it.wdata = pick_wdata();
    it.gen = pick_generation();
    it.probe_ok = 1'($urandom_range(0, 1));
    it.drain = 1'b0;
    return it;
  endfunction

  function automatic fn_op_t cfg_op(input logic [3:0] op, input logic [15:0] off,
                                    input logic [7:0] w, input logic [31:0] data);
    fn_op_t it;
    it = make_op(op, 8'd0);
    it.offset = off;
    it.width = w;
    it.wdata = data;
    return it;
  endfunction

  // Queues one short sequence; most follow the slot lifecycle.
  task automatic queue_chunk(input int unsigned cnt, inout int queued);
    fn_op_t     seq[$];
    fn_op_t     t;
    logic [7:0] s;
    int unsigned r;
    s = pick_slot(cnt);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      seq.push_back(make_op(OP_ADD, s));
    end else if (r < 40) begin
      seq.push_back(make_op(OP_PREPARE, s));
      seq.push_back(make_op(OP_ENABLE, s));
      t = make_op(OP_PROBE, s);
      t.probe_ok = ($urandom_range(0, 3) != 0);
      seq.push_back(t);
      if ($urandom_range(0, 1)) seq.push_back(make_op(OP_QUERY, s));
    end else if (r < 52) begin
      seq.push_back(make_op(OP_REMOVE, s));
      seq.push_back(make_op(OP_ADD, s));
    end else if (r < 62) begin
      seq.push_back(make_op(OP_RESCAN, s));
      seq.push_back(make_op(OP_PREPARE, s));
      seq.push_back(make_op(OP_ENABLE, s));
      t = make_op(OP_PROBE, s);
      t.probe_ok = ($urandom_range(0, 3) != 0);
      seq.push_back(t);
    end else if (r < 77) begin
      repeat ($urandom_range(1, 3))
        seq.push_back(make_op($urandom_range(0, 1) ? OP_READ_CFG : OP_WRITE_CFG, s));
    end else if (r < 87) begin
      seq.push_back(make_op(OP_QUERY, s));
    end else if (r < 94) begin
      // Lifecycle steps in arbitrary order
      repeat (3) seq.push_back(make_op(4'($urandom_range(OP_PREPARE, OP_RESCAN)), s));
    end else begin
      seq.push_back(make_op(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
    end
    n_chunks++;
    if (n_chunks == 50 || $urandom_range(0, 99) < 3) seq[0].drain = 1'b1;
    foreach (seq[i]) pending_ops.push_back(seq[i]);
    queued += seq.size();
  endtask

  task automatic queue_directed();
    fn_op_t t;
    t = make_op(OP_ADD, 8'd0);
    t.gen = '0;
    pending_ops.push_back(t);
    t.gen = '1;
    pending_ops.push_back(t);
    t.gen = 64'd1;
    pending_ops.push_back(t);
    // Slot 0 binds, slot 1 fails its probe and is quarantined.
    pending_ops.push_back(make_op(OP_PREPARE, 8'd0));
    pending_ops.push_back(make_op(OP_ENABLE, 8'd0));
    t = make_op(OP_PROBE, 8'd0);
    t.probe_ok = 1'b1;
    pending_ops.push_back(t);
    pending_ops.push_back(make_op(OP_PREPARE, 8'd1));
    pending_ops.push_back(make_op(OP_ENABLE, 8'd1));
    t = make_op(OP_PROBE, 8'd1);
    t.probe_ok = 1'b0;
    pending_ops.push_back(t);
    pending_ops.push_back(make_op(OP_ENABLE, 8'd1));
    // Prepare while matching is busy
    pending_ops.push_back(make_op(OP_PREPARE, 8'd0));
    pending_ops.push_back(make_op(OP_ENABLE, 8'd0));
    pending_ops.push_back(make_op(OP_PREPARE, 8'd0));
    pending_ops.push_back(make_op(OP_RESCAN, 8'd1));
    // Config space: header, mirror, past the end, bad width
    pending_ops.push_back(cfg_op(OP_READ_CFG, 16'd0, 8'd4, '0));
    pending_ops.push_back(cfg_op(OP_READ_CFG, 16'd44, 8'd2, '0));
    pending_ops.push_back(cfg_op(OP_READ_CFG, 16'd254, 8'd4, '0));
    pending_ops.push_back(cfg_op(OP_READ_CFG, 16'd0, 8'd3, '0));
    pending_ops.push_back(cfg_op(OP_WRITE_CFG, 16'd0, 8'd4, 32'h0));
    pending_ops.push_back(cfg_op(OP_WRITE_CFG, 16'd0, 8'd4, 32'h0100_0000));
    pending_ops.push_back(cfg_op(OP_WRITE_CFG, 16'hffff, 8'd1, 32'h0));
    pending_ops.push_back(make_op(OP_QUERY, 8'd255));
    pending_ops.push_back(make_op(4'hf, 8'd0));
    pending_ops.push_back(make_op(OP_REMOVE, 8'd0));
    pending_ops.push_back(make_op(OP_QUERY, 8'd0));
  endtask

  // Waits until nothing is queued, offered or outstanding.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || n_ops_issued != n_results_seen);
  endtask

  // APB write of the slot count, then a read back.
  task automatic write_slot_count(input logic [ACT_W-1:0] cnt);
    logic [31:0] junk;
    logic [31:0] rd;
    junk = $urandom;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLOTS_ADDR;
    pwdata <= {junk[31:ACT_W], cnt};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    slots_in_use = cnt;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[ACT_W-1:0] !== cnt && count_failure())
      $display("[%0t] slot count read back %0d, wrote %0d", $realtime, rd[ACT_W-1:0], cnt);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ACT_W-1:0] settings [N_PHASES];
    int               queued;
    settings = '{6'd1, 6'd0, 6'd32, 6'd63, 6'd7, 6'd33, 6'd0, 6'd32};
    settings[6] = 6'($urandom_range(2, 31));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    queue_directed();
    for (int p = 0; p < N_PHASES; p++) begin
      wait_for_drain();
      gaps_on = (p % 3) != 1;
      write_slot_count(settings[p]);
      @(negedge clk_i);
      queued = 0;
      while (queued < ((settings[p] >= 1 && settings[p] <= MAX_SLOTS) ? 260 : 60))
        queue_chunk(settings[p], queued);
    end
    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0 && count_failure())
      $display("%0d results never arrived", expected_results.size());
    $display("Ran %0d operations over %0d slot-count settings, with a %0d-cycle result stall.",
             n_results_seen, n_settings, LONG_HOLD);
    $display({"Outcomes: ok %0d, invalid %0d, range %0d, no space %0d, not present %0d, ",
              "busy %0d, not ready %0d, read only %0d"}, stat_hits[ST_OK],
             stat_hits[ST_INVAL], stat_hits[ST_RANGE], stat_hits[ST_NOSPACE],
             stat_hits[ST_NOTPRES], stat_hits[ST_BUSY], stat_hits[ST_NOTREADY],
             stat_hits[ST_RO]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
